// ===== design/frjm_pkg.sv =====
// ============================================================================
// Filament runout and jam monitor package
// Shared widths, constants, register indexes and the mode type.
// ============================================================================
package frjm_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_JAM_DETECT_EN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_STEPS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_COUNT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POLLING_PERIOD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANKING_TIME  = 3'd5;

    localparam logic [14:0] CHUNK_STEPS_RST    = 15'd100;
    localparam logic [7:0]  FILTER_COUNT_RST   = 8'd2;
    localparam logic [9:0]  POLLING_PERIOD_RST = 10'd10;
    localparam logic [9:0]  BLANKING_TIME_RST  = 10'd100;

    localparam logic [7:0] DARK_SHUTTER = 8'd17;
    localparam logic [7:0] BRIGHT_MIN   = 8'd50;
    localparam logic [3:0] JAM_LIMIT    = 4'd10;

    localparam logic [1:0] MODE_CODE_DISABLED = 2'd0;
    localparam logic [1:0] MODE_CODE_INIT     = 2'd1;
    localparam logic [1:0] MODE_CODE_READY    = 2'd2;
    localparam logic [1:0] MODE_CODE_ERROR    = 2'd3;

    typedef enum logic [3:0] {
        MODE_DISABLED = 4'b0001,
        MODE_INIT     = 4'b0010,
        MODE_READY    = 4'b0100,
        MODE_ERROR    = 4'b1000
    } t_mode;

    function automatic logic [1:0] mode_code(input t_mode m);
        logic [1:0] c;
        case (m)
            MODE_INIT:  c = MODE_CODE_INIT;
            MODE_READY: c = MODE_CODE_READY;
            MODE_ERROR: c = MODE_CODE_ERROR;
            default:    c = MODE_CODE_DISABLED;
        endcase
        return c;
    endfunction

endpackage

// ===== design/frjm_in_if.sv =====
// ============================================================================
// Filament monitor input channel
// One sensor tick per item: step delta, sensor readings and status flags.
// ============================================================================
interface frjm_in_if;
    logic              valid;
    logic              ready;
    logic signed [7:0]  step_delta;
    logic signed [15:0] sensor_pos;
    logic [7:0]         shutter;
    logic [7:0]         brightness;
    logic               sensor_fault;
    logic               printing_active;

    modport source (
        output valid, step_delta, sensor_pos, shutter, brightness,
               sensor_fault, printing_active,
        input  ready
    );
    modport sink (
        input  valid, step_delta, sensor_pos, shutter, brightness,
               sensor_fault, printing_active,
        output ready
    );
endinterface

// ===== design/frjm_out_if.sv =====
// ============================================================================
// Filament monitor result channel
// One status item per tick: presence, events, requests and mode.
// ============================================================================
interface frjm_out_if;
    logic       valid;
    logic       ready;
    logic       filament_present;
    logic       presence_event;
    logic       runout_request;
    logic       jam_request;
    logic       stable;
    logic [1:0] mode;

    modport source (
        output valid, filament_present, presence_event, runout_request,
               jam_request, stable, mode,
        input  ready
    );
    modport sink (
        input  valid, filament_present, presence_event, runout_request,
               jam_request, stable, mode,
        output ready
    );
endinterface

// ===== design/filament_runout_jam_monitor.sv =====
// ============================================================================
// Filament runout and jam monitor
// Debounces filament presence, reports presence events and runout, and
// compares extruder steps against sensor motion to detect jams.
// ============================================================================
// The block takes one tick item per clock cycle and returns one registered
// status item for each in the cycle after acceptance. A new item is accepted
// whenever the result register is empty or its item is taken in the same
// cycle, so a continuously ready sink sees full rate. Writing one to the
// enable register restarts initialization; writing zero disables the sensor.
// Write registers only while no item is in flight; the block does not check.
module filament_runout_jam_monitor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [frjm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [frjm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    frjm_in_if.sink                         i_item,
    frjm_out_if.source                      o_result
);

    // Configuration registers.
    logic        r_jam_en;
    logic [14:0] r_chunk_steps;
    logic [7:0]  r_filter_count;
    logic [9:0]  r_polling_period;
    logic [9:0]  r_blanking_time;

    // Monitor state.
    frjm_pkg::t_mode r_mode, n_mode;
    logic [16:0] r_step_accum, n_step_accum;
    logic [15:0] r_last_pos, n_last_pos;
    logic [3:0]  r_jam_errors, n_jam_errors;
    logic [7:0]  r_filter_level, n_filter_level;
    logic        r_filtered, n_filtered;
    logic        r_reported, n_reported;
    logic [9:0]  r_poll_timer, n_poll_timer;
    logic        r_poll_run, n_poll_run;
    logic [10:0] r_blank_timer, n_blank_timer;
    logic        r_blank_run, n_blank_run;

    // Result register.
    logic       r_out_valid;
    logic       r_present;
    logic       r_event;
    logic       r_runout;
    logic       r_jam;
    logic       r_stable;
    logic [1:0] r_mode_code;

    logic        accept;
    logic [17:0] acc_sum;
    logic [16:0] acc_sat;
    logic [16:0] acc_mag;
    logic        chunk_hit;
    logic        steps_fwd;
    logic        sensor_fwd;
    logic        raw_present;
    logic        active;
    logic        fault_hit;
    logic        jam_hit;
    logic        event_hit;
    logic        runout_hit;

    assign i_item.ready = !r_out_valid || o_result.ready;
    assign accept       = i_item.valid && i_item.ready;

    assign acc_sum = {r_step_accum[16], r_step_accum}
                   + {{10{i_item.step_delta[7]}}, i_item.step_delta};
    assign acc_sat = (acc_sum[17] == acc_sum[16]) ? acc_sum[16:0]
                   : (acc_sum[17] ? 17'h10000 : 17'h0FFFF);
    assign acc_mag    = acc_sat[16] ? (~acc_sat + 17'd1) : acc_sat;
    assign chunk_hit  = acc_mag >= {2'b00, r_chunk_steps};
    assign steps_fwd  = !acc_sat[16] && (acc_sat != 17'd0);
    assign sensor_fwd = $signed(i_item.sensor_pos) > $signed(r_last_pos);
    assign raw_present = (i_item.shutter < frjm_pkg::DARK_SHUTTER)
                      || (i_item.brightness >= frjm_pkg::BRIGHT_MIN);
    assign active = (r_mode == frjm_pkg::MODE_INIT) || (r_mode == frjm_pkg::MODE_READY);

    always_comb begin
        n_mode         = r_mode;
        n_step_accum   = acc_sat;
        n_last_pos     = r_last_pos;
        n_jam_errors   = r_jam_errors;
        n_filter_level = r_filter_level;
        n_filtered     = r_filtered;
        n_reported     = r_reported;
        n_poll_run     = r_poll_run;
        n_blank_run    = r_blank_run;
        n_poll_timer   = (r_poll_run && r_poll_timer != '1) ? r_poll_timer + 10'd1
                                                            : r_poll_timer;
        n_blank_timer  = (r_blank_run && r_blank_timer != '1) ? r_blank_timer + 11'd1
                                                              : r_blank_timer;
        fault_hit  = 1'b0;
        jam_hit    = 1'b0;
        event_hit  = 1'b0;
        runout_hit = 1'b0;

        if (active) begin
            if (r_jam_en) begin
                if (chunk_hit) begin
                    n_step_accum = '0;
                    if (i_item.sensor_fault) begin
                        fault_hit      = 1'b1;
                        n_filter_level = '0;
                    end
                    if (sensor_fwd != steps_fwd) begin
                        n_jam_errors = r_jam_errors + 4'd1;
                    end else if (r_jam_errors != '0) begin
                        n_jam_errors = r_jam_errors - 4'd1;
                    end
                    n_last_pos = i_item.sensor_pos;
                end
                if (n_jam_errors > frjm_pkg::JAM_LIMIT) begin
                    n_jam_errors = '0;
                    jam_hit      = 1'b1;
                end
            end
            if (!r_poll_run || n_poll_timer >= r_polling_period) begin
                n_poll_run   = 1'b1;
                n_poll_timer = '0;
                if (i_item.sensor_fault) begin
                    fault_hit      = 1'b1;
                    n_filter_level = '0;
                end
                if (raw_present != r_filtered) begin
                    if (n_filter_level != '1) begin
                        n_filter_level = n_filter_level + 8'd1;
                    end
                end else if (n_filter_level != '0) begin
                    n_filter_level = n_filter_level - 8'd1;
                end
                if (n_filter_level >= r_filter_count) begin
                    n_filter_level = '0;
                    n_filtered     = raw_present;
                end
            end
            if (fault_hit) begin
                n_mode = frjm_pkg::MODE_ERROR;
            end else if (r_mode == frjm_pkg::MODE_INIT) begin
                if (n_filter_level == '0) begin
                    n_reported = n_filtered;
                    n_last_pos = i_item.sensor_pos;
                    n_mode     = frjm_pkg::MODE_READY;
                end
            end else if (!(r_blank_run && n_blank_timer < {1'b0, r_blanking_time})) begin
                if (r_reported != n_filtered) begin
                    n_reported    = n_filtered;
                    n_blank_run   = 1'b1;
                    n_blank_timer = '0;
                    event_hit     = 1'b1;
                    runout_hit    = !n_filtered && i_item.printing_active;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jam_en         <= 1'b0;
            r_chunk_steps    <= frjm_pkg::CHUNK_STEPS_RST;
            r_filter_count   <= frjm_pkg::FILTER_COUNT_RST;
            r_polling_period <= frjm_pkg::POLLING_PERIOD_RST;
            r_blanking_time  <= frjm_pkg::BLANKING_TIME_RST;
            r_mode           <= frjm_pkg::MODE_DISABLED;
            r_step_accum     <= '0;
            r_last_pos       <= '0;
            r_jam_errors     <= '0;
            r_filter_level   <= '0;
            r_filtered       <= 1'b0;
            r_reported       <= 1'b0;
            r_poll_timer     <= '0;
            r_poll_run       <= 1'b0;
            r_blank_timer    <= '0;
            r_blank_run      <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                frjm_pkg::CFG_ENABLE: begin
                    r_filter_level <= '0;
                    if (i_cfg_data[0]) begin
                        r_mode        <= frjm_pkg::MODE_INIT;
                        r_jam_errors  <= '0;
                        r_step_accum  <= '0;
                        r_poll_timer  <= '0;
                        r_poll_run    <= 1'b0;
                        r_blank_timer <= '0;
                        r_blank_run   <= 1'b0;
                    end else begin
                        r_mode <= frjm_pkg::MODE_DISABLED;
                    end
                end
                frjm_pkg::CFG_JAM_DETECT_EN:  r_jam_en         <= i_cfg_data[0];
                frjm_pkg::CFG_CHUNK_STEPS:    r_chunk_steps    <= i_cfg_data[14:0];
                frjm_pkg::CFG_FILTER_COUNT:   r_filter_count   <= i_cfg_data[7:0];
                frjm_pkg::CFG_POLLING_PERIOD: r_polling_period <= i_cfg_data[9:0];
                frjm_pkg::CFG_BLANKING_TIME:  r_blanking_time  <= i_cfg_data[9:0];
                default: begin
                end
            endcase
        end else if (accept) begin
            r_mode         <= n_mode;
            r_step_accum   <= n_step_accum;
            r_last_pos     <= n_last_pos;
            r_jam_errors   <= n_jam_errors;
            r_filter_level <= n_filter_level;
            r_filtered     <= n_filtered;
            r_reported     <= n_reported;
            r_poll_timer   <= n_poll_timer;
            r_poll_run     <= n_poll_run;
            r_blank_timer  <= n_blank_timer;
            r_blank_run    <= n_blank_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_present   <= n_filtered;
            r_event     <= event_hit;
            r_runout    <= runout_hit;
            r_jam       <= jam_hit;
            r_stable    <= (n_filter_level == '0);
            r_mode_code <= frjm_pkg::mode_code(n_mode);
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.filament_present = r_present;
    assign o_result.presence_event   = r_event;
    assign o_result.runout_request   = r_runout;
    assign o_result.jam_request      = r_jam;
    assign o_result.stable           = r_stable;
    assign o_result.mode             = r_mode_code;

endmodule

// ===== bench/filament_runout_jam_monitor_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Filament runout and jam monitor testbench
// Drives sensor ticks with random idle gaps, predicts every status item with
// an independent model of the monitor, and checks each status field. A short
// table of directed ticks comes first, followed by random phases that each
// program a new register setting.
// ============================================================================
module filament_runout_jam_monitor_test;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic signed [7:0]  step_delta;
        logic signed [15:0] sensor_pos;
        logic [7:0]         shutter;
        logic [7:0]         brightness;
        logic               sensor_fault;
        logic               printing_active;
    } t_tick;

    typedef struct packed {
        logic       present;
        logic       changed;
        logic       runout;
        logic       jam;
        logic       stable;
        logic [1:0] mode;
    } t_status;

    typedef enum logic [1:0] {ROW_REG, ROW_TICK, ROW_TICK_KNOWN} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [2:0]  idx;
        int unsigned value;
        t_tick       tick;
        t_status     want;
    } t_plan_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [frjm_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [frjm_pkg::CFG_DATA_W-1:0] i_cfg_data;

    frjm_in_if  tick_ch();
    frjm_out_if status_ch();

    filament_runout_jam_monitor dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (tick_ch),
        .o_result   (status_ch)
    );

    // Register shadow and monitor state of the predictor.
    bit          r_jam_en;
    int          r_chunk, r_filter, r_period, r_blank;
    logic [1:0]  m_mode;
    int          m_accum, m_last_pos, m_jam_errs, m_level;
    bit          m_present, m_reported;
    int          m_poll_t, m_blank_t;
    bit          m_poll_on, m_blank_on;

    t_status     pending_status[$];
    t_plan_row   plan[$];

    // Tick generator state.
    bit                 g_present, g_dir, g_agree, g_print, g_sat, g_sat_up, fault_tail;
    int                 g_run;
    logic signed [15:0] g_pos;

    bit calm, long_hold, cfg_active;
    int n_ticks, n_settings, n_mismatch, n_changes, n_runouts, n_jams, cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Run stopped at the cycle limit with %0d status items pending.",
                 pending_status.size());
        $display("TB_ERROR");
        $finish;
    end

    function automatic int draw_gap();
        return calm ? 0 : int'($urandom_range(0, 16));
    endfunction

    task automatic flag(input string msg);
        $display("MISMATCH: %s", msg);
        n_mismatch++;
    endtask

    task automatic check_field(input string name, input logic [1:0] got,
                               input logic [1:0] want, input int num);
        if (got !== want) begin
            flag($sformatf("status %0d %s is %0d, expected %0d", num, name, got, want));
        end
    endtask

    task automatic apply_reg(input logic [2:0] idx, input int unsigned v);
        case (idx)
            frjm_pkg::CFG_ENABLE: begin
                if (v[0]) begin
                    m_mode = frjm_pkg::MODE_CODE_INIT;
                    m_jam_errs = 0;
                    m_accum = 0;
                    m_poll_t = 0;
                    m_poll_on = 0;
                    m_blank_t = 0;
                    m_blank_on = 0;
                end else begin
                    m_mode = frjm_pkg::MODE_CODE_DISABLED;
                end
                m_level = 0;
            end
            frjm_pkg::CFG_JAM_DETECT_EN:  r_jam_en = v[0];
            frjm_pkg::CFG_CHUNK_STEPS:    r_chunk = int'(v & 32'h7fff);
            frjm_pkg::CFG_FILTER_COUNT:   r_filter = int'(v & 32'hff);
            frjm_pkg::CFG_POLLING_PERIOD: r_period = int'(v & 32'h3ff);
            frjm_pkg::CFG_BLANKING_TIME:  r_blank = int'(v & 32'h3ff);
            default: ;
        endcase
    endtask

    function automatic t_status predict_status(input t_tick t);
        int sum, mag, pos;
        bit raw, hit;
        t_status s;
        s = '0;
        hit = 0;
        pos = int'($signed(t.sensor_pos));
        m_accum += int'($signed(t.step_delta));
        if (m_accum > 65535) m_accum = 65535;
        if (m_accum < -65536) m_accum = -65536;
        if (m_poll_on && m_poll_t < 1023) m_poll_t++;
        if (m_blank_on && m_blank_t < 2047) m_blank_t++;
        if (m_mode == frjm_pkg::MODE_CODE_INIT || m_mode == frjm_pkg::MODE_CODE_READY) begin
            if (r_jam_en) begin
                sum = m_accum;
                mag = (sum < 0) ? -sum : sum;
                if (mag >= r_chunk) begin
                    m_accum = 0;
                    if (t.sensor_fault) begin
                        hit = 1;
                        m_level = 0;
                    end
                    if ((pos > m_last_pos) != (sum > 0)) begin
                        m_jam_errs++;
                    end else if (m_jam_errs != 0) begin
                        m_jam_errs--;
                    end
                    m_last_pos = pos;
                end
                if (m_jam_errs > int'(frjm_pkg::JAM_LIMIT)) begin
                    m_jam_errs = 0;
                    s.jam = 1'b1;
                end
            end
            if (!m_poll_on || m_poll_t >= r_period) begin
                m_poll_on = 1;
                m_poll_t = 0;
                if (t.sensor_fault) begin
                    hit = 1;
                    m_level = 0;
                end
                raw = (t.shutter < frjm_pkg::DARK_SHUTTER)
                   || (t.brightness >= frjm_pkg::BRIGHT_MIN);
                if (raw != m_present) begin
                    if (m_level < 255) m_level++;
                end else if (m_level != 0) begin
                    m_level--;
                end
                if (m_level >= r_filter) begin
                    m_level = 0;
                    m_present = raw;
                end
            end
            if (hit) begin
                m_mode = frjm_pkg::MODE_CODE_ERROR;
            end else if (m_mode == frjm_pkg::MODE_CODE_INIT) begin
                if (m_level == 0) begin
                    m_reported = m_present;
                    m_last_pos = pos;
                    m_mode = frjm_pkg::MODE_CODE_READY;
                end
            end else if (!(m_blank_on && m_blank_t < r_blank)) begin
                if (m_reported != m_present) begin
                    m_reported = m_present;
                    m_blank_on = 1;
                    m_blank_t = 0;
                    s.changed = 1'b1;
                    s.runout = !m_present && t.printing_active;
                end
            end
        end
        s.present = m_present;
        s.stable = (m_level == 0);
        s.mode = m_mode;
        return s;
    endfunction

    function automatic t_tick tk(input int delta, input int pos, input int sh,
                                 input int br, input bit flt, input bit prt);
        t_tick t;
        t.step_delta = delta[7:0];
        t.sensor_pos = pos[15:0];
        t.shutter = sh[7:0];
        t.brightness = br[7:0];
        t.sensor_fault = flt;
        t.printing_active = prt;
        return t;
    endfunction

    function automatic t_status st(input bit pr, input bit ch, input bit ro,
                                   input bit jm, input bit sb, input logic [1:0] md);
        t_status s;
        s.present = pr;
        s.changed = ch;
        s.runout = ro;
        s.jam = jm;
        s.stable = sb;
        s.mode = md;
        return s;
    endfunction

    function automatic void add_reg(input logic [2:0] idx, input int unsigned v);
        t_plan_row r;
        r.kind = ROW_REG;
        r.idx = idx;
        r.value = v;
        r.tick = '0;
        r.want = '0;
        plan.push_back(r);
    endfunction

    function automatic void add_tick(input t_tick t, input bit known, input t_status w);
        t_plan_row r;
        r.kind = known ? ROW_TICK_KNOWN : ROW_TICK;
        r.idx = '0;
        r.value = 0;
        r.tick = t;
        r.want = w;
        plan.push_back(r);
    endfunction

    function automatic t_tick make_tick(input int k, input int n);
        t_tick t;
        int step;
        if (g_run == 0) begin
            g_run = int'($urandom_range(1, 24));
            if ($urandom_range(0, 1)) g_present = !g_present;
            if ($urandom_range(0, 2) == 0) g_dir = !g_dir;
            if ($urandom_range(0, 1)) g_agree = !g_agree;
            if ($urandom_range(0, 3) == 0) g_print = !g_print;
        end
        g_run--;
        if (g_present) begin
            if ($urandom_range(0, 1)) begin
                t.shutter = 8'($urandom_range(0, 16));
                t.brightness = 8'($urandom);
            end else begin
                t.shutter = 8'($urandom);
                t.brightness = 8'($urandom_range(50, 255));
            end
        end else begin
            t.shutter = 8'($urandom_range(17, 255));
            t.brightness = 8'($urandom_range(0, 49));
        end
        if ($urandom_range(0, 15) == 0) begin
            t.shutter = 8'($urandom);
            t.brightness = 8'($urandom);
        end
        if (g_sat) begin
            step = g_sat_up ? int'($urandom_range(100, 127))
                            : -int'($urandom_range(100, 128));
        end else begin
            step = g_dir ? int'($urandom_range(0, 127)) : -int'($urandom_range(0, 128));
        end
        if (!g_sat && $urandom_range(0, 9) == 0) step = int'($signed(8'($urandom)));
        t.step_delta = step[7:0];
        if ((step > 0) == g_agree) begin
            g_pos = g_pos + 16'($urandom_range(1, 40));
        end else begin
            g_pos = g_pos - 16'($urandom_range(0, 40));
        end
        if ($urandom_range(0, 19) == 0) g_pos = 16'($urandom);
        t.sensor_pos = g_pos;
        t.sensor_fault = fault_tail && (k >= n - n / 8) && ($urandom_range(0, 5) == 0);
        t.printing_active = g_print;
        return t;
    endfunction

    task automatic set_reg(input logic [2:0] idx, input int unsigned v);
        if (!cfg_active) begin
            tick_ch.valid <= 1'b0;
            while (pending_status.size() != 0) @(posedge i_clk);
            repeat (2) @(posedge i_clk);
            cfg_active = 1;
            n_settings++;
        end
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v[frjm_pkg::CFG_DATA_W-1:0];
        @(posedge i_clk);
        apply_reg(idx, v);
    endtask

    task automatic send_tick(input t_tick t, input bit known, input t_status w);
        int gap;
        t_status p;
        gap = draw_gap();
        if (cfg_active) begin
            i_cfg_we <= 1'b0;
            cfg_active = 0;
        end
        if (gap > 0) begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.step_delta <= t.step_delta;
        tick_ch.sensor_pos <= t.sensor_pos;
        tick_ch.shutter <= t.shutter;
        tick_ch.brightness <= t.brightness;
        tick_ch.sensor_fault <= t.sensor_fault;
        tick_ch.printing_active <= t.printing_active;
        do @(posedge i_clk); while (!(tick_ch.valid === 1'b1 && tick_ch.ready === 1'b1));
        p = predict_status(t);
        pending_status.push_back(known ? w : p);
        n_ticks++;
    endtask

    initial begin : status_sink
        int gap, num;
        t_status got, want;
        num = 0;
        status_ch.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            gap = draw_gap();
            if (long_hold) begin
                long_hold = 0;
                gap = 200;
            end
            if (gap > 0) begin
                status_ch.ready <= 1'b0;
                for (int c = 0; c < gap; c++) @(posedge i_clk);
            end
            status_ch.ready <= 1'b1;
            do @(posedge i_clk);
            while (!(status_ch.valid === 1'b1 && status_ch.ready === 1'b1));
            got.present = status_ch.filament_present;
            got.changed = status_ch.presence_event;
            got.runout = status_ch.runout_request;
            got.jam = status_ch.jam_request;
            got.stable = status_ch.stable;
            got.mode = status_ch.mode;
            num++;
            if (pending_status.size() == 0) begin
                flag($sformatf("status %0d arrived with no tick pending", num));
            end else begin
                want = pending_status.pop_front();
                check_field("filament_present", got.present, want.present, num);
                check_field("presence_event", got.changed, want.changed, num);
                check_field("runout_request", got.runout, want.runout, num);
                check_field("jam_request", got.jam, want.jam, num);
                check_field("stable", got.stable, want.stable, num);
                check_field("mode", got.mode, want.mode, num);
                if (want.changed) n_changes++;
                if (want.runout) n_runouts++;
                if (want.jam) n_jams++;
            end
        end
    end

    initial begin : stimulus
        int n;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        tick_ch.valid <= 1'b0;
        tick_ch.step_delta <= '0;
        tick_ch.sensor_pos <= '0;
        tick_ch.shutter <= '0;
        tick_ch.brightness <= '0;
        tick_ch.sensor_fault <= 1'b0;
        tick_ch.printing_active <= 1'b0;
        r_jam_en = 0;
        r_chunk = int'(frjm_pkg::CHUNK_STEPS_RST);
        r_filter = int'(frjm_pkg::FILTER_COUNT_RST);
        r_period = int'(frjm_pkg::POLLING_PERIOD_RST);
        r_blank = int'(frjm_pkg::BLANKING_TIME_RST);
        m_mode = frjm_pkg::MODE_CODE_DISABLED;
        g_pos = '0;
        calm = 1;

        // Disabled after reset, fields at both extremes.
        add_tick(tk(-128, -32768, 0, 0, 0, 0), 1,
                 st(0, 0, 0, 0, 1, frjm_pkg::MODE_CODE_DISABLED));
        add_tick(tk(127, 32767, 255, 255, 1, 1), 1,
                 st(0, 0, 0, 0, 1, frjm_pkg::MODE_CODE_DISABLED));
        // Fastest filter, polling every tick, no blanking.
        add_reg(frjm_pkg::CFG_FILTER_COUNT, 1);
        add_reg(frjm_pkg::CFG_POLLING_PERIOD, 1);
        add_reg(frjm_pkg::CFG_BLANKING_TIME, 0);
        add_reg(frjm_pkg::CFG_ENABLE, 1);
        add_tick(tk(0, 0, 0, 0, 0, 0), 1, st(1, 0, 0, 0, 1, frjm_pkg::MODE_CODE_READY));
        add_tick(tk(0, 0, 255, 0, 0, 1), 1, st(0, 1, 1, 0, 1, frjm_pkg::MODE_CODE_READY));
        add_tick(tk(0, 0, 16, 49, 0, 1), 1, st(1, 1, 0, 0, 1, frjm_pkg::MODE_CODE_READY));
        add_tick(tk(0, 0, 17, 49, 0, 0), 1, st(0, 1, 0, 0, 1, frjm_pkg::MODE_CODE_READY));
        add_tick(tk(0, 0, 255, 50, 0, 1), 1, st(1, 1, 0, 0, 1, frjm_pkg::MODE_CODE_READY));
        // Forward steps while the sensor runs backward, eleven chunks in a row.
        add_reg(frjm_pkg::CFG_JAM_DETECT_EN, 1);
        add_reg(frjm_pkg::CFG_CHUNK_STEPS, 1);
        for (int j = 1; j <= 11; j++) begin
            add_tick(tk(127, -j, 0, 0, 0, 1), j == 11,
                     st(1, 0, 0, 1, 1, frjm_pkg::MODE_CODE_READY));
        end
        // A failed read puts the sensor in error until the enable register is written.
        add_tick(tk(0, -11, 0, 0, 1, 0), 1, st(1, 0, 0, 0, 1, frjm_pkg::MODE_CODE_ERROR));
        add_tick(tk(-128, 32767, 255, 0, 1, 1), 1,
                 st(1, 0, 0, 0, 1, frjm_pkg::MODE_CODE_ERROR));
        add_reg(frjm_pkg::CFG_ENABLE, 0);
        add_tick(tk(5, 100, 0, 0, 0, 0), 1, st(1, 0, 0, 0, 1, frjm_pkg::MODE_CODE_DISABLED));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                set_reg(plan[i].idx, plan[i].value);
            end else begin
                send_tick(plan[i].tick, plan[i].kind == ROW_TICK_KNOWN, plan[i].want);
            end
        end

        for (int p = 0; p < 9; p++) begin
            calm = (p % 3 == 0);
            fault_tail = 1;
            g_sat = 0;
            n = 50;
            case (p)
                0: begin
                    set_reg(frjm_pkg::CFG_FILTER_COUNT, 2);
                    set_reg(frjm_pkg::CFG_POLLING_PERIOD, 1);
                    set_reg(frjm_pkg::CFG_BLANKING_TIME, 3);
                    set_reg(frjm_pkg::CFG_CHUNK_STEPS, $urandom_range(40, 200));
                    set_reg(frjm_pkg::CFG_JAM_DETECT_EN, 1);
                    set_reg(frjm_pkg::CFG_ENABLE, 1);
                    long_hold = 1;
                end
                1: begin
                    set_reg(frjm_pkg::CFG_FILTER_COUNT, 1);
                    set_reg(frjm_pkg::CFG_POLLING_PERIOD, 1);
                    set_reg(frjm_pkg::CFG_BLANKING_TIME, 0);
                    set_reg(frjm_pkg::CFG_CHUNK_STEPS, 1);
                    set_reg(frjm_pkg::CFG_JAM_DETECT_EN, 1);
                    set_reg(frjm_pkg::CFG_ENABLE, 1);
                    n = 40;
                end
                2: begin
                    set_reg(frjm_pkg::CFG_FILTER_COUNT, 255);
                    set_reg(frjm_pkg::CFG_POLLING_PERIOD, 1023);
                    set_reg(frjm_pkg::CFG_BLANKING_TIME, 1023);
                    set_reg(frjm_pkg::CFG_CHUNK_STEPS, 32767);
                    set_reg(frjm_pkg::CFG_JAM_DETECT_EN, 1);
                    set_reg(frjm_pkg::CFG_ENABLE, 1);
                    n = 20;
                end
                5: begin
                    // Long one-way feed with jam detection off builds a large
                    // step sum for the next phase.
                    set_reg(frjm_pkg::CFG_FILTER_COUNT, $urandom_range(1, 3));
                    set_reg(frjm_pkg::CFG_POLLING_PERIOD, $urandom_range(1, 3));
                    set_reg(frjm_pkg::CFG_BLANKING_TIME, $urandom_range(0, 10));
                    set_reg(frjm_pkg::CFG_JAM_DETECT_EN, 0);
                    set_reg(frjm_pkg::CFG_ENABLE, 1);
                    g_sat = 1;
                    g_sat_up = 1'($urandom_range(0, 1));
                    fault_tail = 0;
                    n = 280;
                end
                6: begin
                    set_reg(frjm_pkg::CFG_JAM_DETECT_EN, 1);
                    set_reg(frjm_pkg::CFG_CHUNK_STEPS, 32767);
                    fault_tail = 0;
                    n = 20;
                end
                7: begin
                    set_reg(frjm_pkg::CFG_ENABLE, 0);
                    n = 15;
                end
                default: begin
                    set_reg(frjm_pkg::CFG_FILTER_COUNT, $urandom_range(1, 4));
                    set_reg(frjm_pkg::CFG_POLLING_PERIOD, $urandom_range(1, 4));
                    set_reg(frjm_pkg::CFG_BLANKING_TIME, $urandom_range(0, 20));
                    set_reg(frjm_pkg::CFG_CHUNK_STEPS, $urandom_range(1, 120));
                    set_reg(frjm_pkg::CFG_JAM_DETECT_EN, $urandom_range(0, 1));
                    set_reg(frjm_pkg::CFG_ENABLE, 1);
                end
            endcase
            for (int k = 0; k < n; k++) begin
                send_tick(make_tick(k, n), 0, '0);
            end
        end

        tick_ch.valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Covered %0d ticks under %0d register settings, with %0d presence events,",
                 n_ticks, n_settings, n_changes);
        $display("%0d runout requests and %0d jam requests; %0d mismatches.",
                 n_runouts, n_jams, n_mismatch);
        if (n_mismatch == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
